FILE: rtl/core/sbwl_pkg.sv
package sbwl_pkg;

  // Default geometry of the strip
  localparam int GROUP_ONE_COUNT_DEF = 8;
  localparam int GROUP_TWO_COUNT_DEF = 8;
  localparam int WAVE_COUNT_DEF      = 16;
  localparam int GROUP_ONE_START_DEF = 0;
  localparam int GROUP_TWO_START_DEF = 8;
  localparam int WAVE_START_DEF      = 16;

  localparam int MAX_LEDS = 64;
  localparam int IDX_W    = 6;   // led_index width
  localparam int CNT_W    = 5;   // LED counter inside one group (up to 32 LEDs)
  localparam int N_W      = 7;   // results emitted in one frame (0..64)

  // Status codes
  localparam logic [1:0] STATUS_NORMAL   = 2'd0;
  localparam logic [1:0] STATUS_NET_DOWN = 2'd1;
  localparam logic [1:0] STATUS_CAN1_ERR = 2'd2;
  localparam logic [1:0] STATUS_CAN2_ERR = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_FRAME_MS    = 3'd0;
  localparam logic [2:0] REG_WAVE_PERIOD = 3'd1;
  localparam logic [2:0] REG_FADE        = 3'd2;
  localparam logic [2:0] REG_FLOOR       = 3'd3;
  localparam logic [2:0] REG_WAVE_RED    = 3'd4;
  localparam logic [2:0] REG_WAVE_GREEN  = 3'd5;
  localparam logic [2:0] REG_WAVE_BLUE   = 3'd6;

  // Register reset values
  localparam logic [7:0]  FRAME_MS_RST    = 8'd20;
  localparam logic [7:0]  WAVE_PERIOD_RST = 8'd60;
  localparam logic [15:0] FADE_RST        = 16'd53740;
  localparam logic [15:0] FLOOR_RST       = 16'd655;
  localparam logic [7:0]  WAVE_RED_RST    = 8'd0;
  localparam logic [7:0]  WAVE_GREEN_RST  = 8'd255;
  localparam logic [7:0]  WAVE_BLUE_RST   = 8'd255;

  // Status colour levels
  localparam logic [7:0]  LIT_LEVEL     = 8'd127;
  localparam logic [7:0]  ORANGE_GREEN  = 8'd63;
  localparam logic [7:0]  NORMAL_LEVEL  = 8'd80;
  localparam logic [15:0] FULL_LEVEL    = 16'hFFFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Controller to datapath
  typedef struct packed {
    logic             start;      // frame request accepted: advance timers, capture codes
    logic             grp_two;    // status LED belongs to group 2
    logic             wave_calc;  // scale one brightness entry by the fade factor
    logic             wave_done;  // floor, write back and scale the wave colour
    logic             emit;       // load the output register
    logic             last;       // final result of the frame
    logic [CNT_W-1:0] item;       // LED within its group
    logic [IDX_W-1:0] led_index;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

  // dark100 / dark250: odd quotient of the blink timer by that phase
  function automatic rgb_t status_colour(logic [1:0] code, logic dark100, logic dark250);
    rgb_t c;
    c = '0;
    case (code)
      STATUS_NET_DOWN: begin
        if (!dark100) c.red = LIT_LEVEL;
      end
      STATUS_CAN1_ERR: begin
        if (!dark250) begin
          c.red   = LIT_LEVEL;
          c.green = LIT_LEVEL;
        end
      end
      STATUS_CAN2_ERR: begin
        if (!dark250) begin
          c.red   = LIT_LEVEL;
          c.green = ORANGE_GREEN;
        end
      end
      default: begin
        c.red   = NORMAL_LEVEL;
        c.green = NORMAL_LEVEL;
        c.blue  = NORMAL_LEVEL;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/status_blink_and_wave_led_frames.sv
// Status blink and wave LED frame generator. Each accepted request on the slave
// stream is one frame tick with two status codes; the block answers with one
// color per LED on the master stream: GROUP_ONE_COUNT LEDs in the color of
// status one, GROUP_TWO_COUNT LEDs in the color of status two, then WAVE_COUNT
// LEDs of a fading wave, tlast on the final LED (at most 64 LEDs per frame).
// Net down blinks red with a 100 ms phase, CAN1 / CAN2 errors blink yellow /
// orange with a 250 ms phase, normal is dim white. A frame is accepted in the
// idle state; then the status LEDs follow, one LED per cycle unless the master
// side stalls, and each wave LED takes two steps, one to scale the stored
// brightness by the fade factor and one to floor it, write it back and scale
// the wave color, the single shared fade multiplier walking the brightness
// store. The output register lets the next frame be accepted while the final
// LED still waits. The brightness store is cleared by reset at once.
// Configuration writes are always taken (cfg_ready stays high); write them
// only between frames.
module status_blink_and_wave_led_frames #(
  parameter int GROUP_ONE_COUNT = sbwl_pkg::GROUP_ONE_COUNT_DEF,
  parameter int GROUP_TWO_COUNT = sbwl_pkg::GROUP_TWO_COUNT_DEF,
  parameter int WAVE_COUNT      = sbwl_pkg::WAVE_COUNT_DEF,
  parameter int GROUP_ONE_START = sbwl_pkg::GROUP_ONE_START_DEF,
  parameter int GROUP_TWO_START = sbwl_pkg::GROUP_TWO_START_DEF,
  parameter int WAVE_START      = sbwl_pkg::WAVE_START_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Frame tick
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] status_one, [3:2] status_two, [7:4] zero
  // LED colors
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [5:0] led_index, [13:6] red, [21:14] green,
                                      // [29:22] blue, [31:30] zero
  output logic        m_axis_tlast,   // last_led
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sbwl_pkg::cmd_t  cmd;
  sbwl_pkg::stat_t stat;
  sbwl_pkg::rgb_t  out_rgb;
  logic [sbwl_pkg::IDX_W-1:0] led_index;

  assign cfg_ready = 1'b1;

  sbwl_ctrl #(
    .GROUP_ONE_COUNT (GROUP_ONE_COUNT),
    .GROUP_TWO_COUNT (GROUP_TWO_COUNT),
    .WAVE_COUNT      (WAVE_COUNT),
    .GROUP_ONE_START (GROUP_ONE_START),
    .GROUP_TWO_START (GROUP_TWO_START),
    .WAVE_START      (WAVE_START)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbwl_dp #(
    .WAVE_COUNT (WAVE_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status_one (s_axis_tdata[1:0]),
    .status_two (s_axis_tdata[3:2]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .led_index  (led_index),
    .out_rgb    (out_rgb),
    .last_led   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_rgb.blue, out_rgb.green, out_rgb.red, led_index};

endmodule

FILE: rtl/core/sbwl_ctrl.sv
module sbwl_ctrl #(
  parameter int GROUP_ONE_COUNT = sbwl_pkg::GROUP_ONE_COUNT_DEF,
  parameter int GROUP_TWO_COUNT = sbwl_pkg::GROUP_TWO_COUNT_DEF,
  parameter int WAVE_COUNT      = sbwl_pkg::WAVE_COUNT_DEF,
  parameter int GROUP_ONE_START = sbwl_pkg::GROUP_ONE_START_DEF,
  parameter int GROUP_TWO_START = sbwl_pkg::GROUP_TWO_START_DEF,
  parameter int WAVE_START      = sbwl_pkg::WAVE_START_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sbwl_pkg::stat_t stat,
  output sbwl_pkg::cmd_t  cmd
);

  localparam int CNT_W = sbwl_pkg::CNT_W;
  localparam int N_W   = sbwl_pkg::N_W;
  localparam int IDX_W = sbwl_pkg::IDX_W;
  localparam int TOTAL = GROUP_ONE_COUNT + GROUP_TWO_COUNT + WAVE_COUNT;
  localparam int CAP   = (TOTAL > sbwl_pkg::MAX_LEDS) ? sbwl_pkg::MAX_LEDS : TOTAL;

  localparam logic [CNT_W-1:0] G1_LAST   = CNT_W'(GROUP_ONE_COUNT - 1);
  localparam logic [CNT_W-1:0] G2_LAST   = CNT_W'(GROUP_TWO_COUNT - 1);
  localparam logic [CNT_W-1:0] WAVE_LAST = CNT_W'(WAVE_COUNT - 1);
  localparam logic [IDX_W-1:0] G1_BASE   = IDX_W'(GROUP_ONE_START);
  localparam logic [IDX_W-1:0] G2_BASE   = IDX_W'(GROUP_TWO_START);
  localparam logic [IDX_W-1:0] WAVE_BASE = IDX_W'(WAVE_START);
  localparam logic [N_W-1:0]   N_CAP     = N_W'(sbwl_pkg::MAX_LEDS);
  localparam logic [N_W-1:0]   N_LAST    = N_W'(CAP - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_GRP   = 2'd1;
  localparam logic [1:0] S_WCALC = 2'd2;
  localparam logic [1:0] S_WOUT  = 2'd3;

  logic [1:0]       state, state_next;
  logic             grp_two, grp_two_next;
  logic [CNT_W-1:0] item, item_next;
  logic [N_W-1:0]   n, n_next;
  logic             emit_ok;
  logic             go;
  logic [IDX_W-1:0] base;

  assign emit_ok = (n < N_CAP);
  assign go      = stat.out_free || !emit_ok;

  always_comb begin
    case (state)
      S_GRP:   base = grp_two ? G2_BASE : G1_BASE;
      default: base = WAVE_BASE;
    endcase
  end

  always_comb begin
    state_next    = state;
    grp_two_next  = grp_two;
    item_next     = item;
    n_next        = n;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.grp_two   = grp_two;
    cmd.item      = item;
    cmd.last      = (n == N_LAST);
    cmd.led_index = base + {{(IDX_W-CNT_W){1'b0}}, item};
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start    = 1'b1;
          state_next   = S_GRP;
          grp_two_next = 1'b0;
          item_next    = '0;
          n_next       = '0;
        end
      end
      S_GRP: begin
        if (go) begin
          cmd.emit     = emit_ok;
          if (emit_ok) n_next = n + 1'b1;
          if (item == (grp_two ? G2_LAST : G1_LAST)) begin
            item_next = '0;
            if (grp_two) state_next = S_WCALC;
            else grp_two_next = 1'b1;
          end else begin
            item_next = item + 1'b1;
          end
        end
      end
      S_WCALC: begin
        cmd.wave_calc = 1'b1;
        state_next    = S_WOUT;
      end
      S_WOUT: begin
        if (go) begin
          cmd.wave_done = 1'b1;
          cmd.emit      = emit_ok;
          if (emit_ok) n_next = n + 1'b1;
          if (item == WAVE_LAST) begin
            state_next = S_IDLE;
          end else begin
            item_next  = item + 1'b1;
            state_next = S_WCALC;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      grp_two <= 1'b0;
      item    <= '0;
      n       <= '0;
    end else begin
      state   <= state_next;
      grp_two <= grp_two_next;
      item    <= item_next;
      n       <= n_next;
    end
  end

endmodule

FILE: rtl/core/sbwl_dp.sv
module sbwl_dp #(
  parameter int WAVE_COUNT = sbwl_pkg::WAVE_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [15:0]                cfg_data,
  input  logic [1:0]                 status_one,
  input  logic [1:0]                 status_two,
  input  sbwl_pkg::cmd_t             cmd,
  output sbwl_pkg::stat_t            stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sbwl_pkg::IDX_W-1:0] led_index,
  output sbwl_pkg::rgb_t             out_rgb,
  output logic                       last_led
);

  localparam int WIDX_W = $clog2(WAVE_COUNT);
  localparam logic [WIDX_W-1:0] HEAD_LAST = WIDX_W'(WAVE_COUNT - 1);

  // Configuration registers
  logic [7:0]  frame_ms, wave_period_ms, wave_red, wave_green, wave_blue;
  logic [15:0] fade_factor, floor_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ms       <= sbwl_pkg::FRAME_MS_RST;
      wave_period_ms <= sbwl_pkg::WAVE_PERIOD_RST;
      fade_factor    <= sbwl_pkg::FADE_RST;
      floor_level    <= sbwl_pkg::FLOOR_RST;
      wave_red       <= sbwl_pkg::WAVE_RED_RST;
      wave_green     <= sbwl_pkg::WAVE_GREEN_RST;
      wave_blue      <= sbwl_pkg::WAVE_BLUE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sbwl_pkg::REG_FRAME_MS:    frame_ms       <= cfg_data[7:0];
        sbwl_pkg::REG_WAVE_PERIOD: wave_period_ms <= cfg_data[7:0];
        sbwl_pkg::REG_FADE:        fade_factor    <= cfg_data;
        sbwl_pkg::REG_FLOOR:       floor_level    <= cfg_data;
        sbwl_pkg::REG_WAVE_RED:    wave_red       <= cfg_data[7:0];
        sbwl_pkg::REG_WAVE_GREEN:  wave_green     <= cfg_data[7:0];
        sbwl_pkg::REG_WAVE_BLUE:   wave_blue      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Blink timer, kept with its remainder and quotient parity per phase
  logic [31:0] blink_ms;
  logic [6:0]  rem100;
  logic [7:0]  rem250;
  logic        dark100, dark250;
  logic [32:0] blink_sum;
  logic [7:0]  wrap_lo;
  logic [8:0]  s100, s250;
  logic [6:0]  rem100_next;
  logic [7:0]  rem250_next;
  logic        dark100_next, dark250_next;

  assign blink_sum = {1'b0, blink_ms} + {25'd0, frame_ms};
  assign wrap_lo   = blink_sum[7:0];
  assign s100      = {2'b00, rem100} + {1'b0, frame_ms};
  assign s250      = {1'b0, rem250} + {1'b0, frame_ms};

  always_comb begin
    if (blink_sum[32]) begin
      // Timer wrapped: the new value is below 256, restart the phases from it
      if (wrap_lo >= 8'd200) begin
        rem100_next  = 7'(wrap_lo - 8'd200);
        dark100_next = 1'b0;
      end else if (wrap_lo >= 8'd100) begin
        rem100_next  = 7'(wrap_lo - 8'd100);
        dark100_next = 1'b1;
      end else begin
        rem100_next  = wrap_lo[6:0];
        dark100_next = 1'b0;
      end
      if (wrap_lo >= 8'd250) begin
        rem250_next  = wrap_lo - 8'd250;
        dark250_next = 1'b1;
      end else begin
        rem250_next  = wrap_lo;
        dark250_next = 1'b0;
      end
    end else begin
      if (s100 >= 9'd300) begin
        rem100_next  = 7'(s100 - 9'd300);
        dark100_next = ~dark100;
      end else if (s100 >= 9'd200) begin
        rem100_next  = 7'(s100 - 9'd200);
        dark100_next = dark100;
      end else if (s100 >= 9'd100) begin
        rem100_next  = 7'(s100 - 9'd100);
        dark100_next = ~dark100;
      end else begin
        rem100_next  = s100[6:0];
        dark100_next = dark100;
      end
      if (s250 >= 9'd500) begin
        rem250_next  = 8'(s250 - 9'd500);
        dark250_next = dark250;
      end else if (s250 >= 9'd250) begin
        rem250_next  = 8'(s250 - 9'd250);
        dark250_next = ~dark250;
      end else begin
        rem250_next  = s250[7:0];
        dark250_next = dark250;
      end
    end
  end

  // Wave timer and head
  logic [8:0]        wave_ms, wave_sum;
  logic [WIDX_W-1:0] head, load_pos;
  logic              load_flag;
  logic              wave_hit;

  assign wave_sum = wave_ms + {1'b0, frame_ms};
  assign wave_hit = (wave_sum >= {1'b0, wave_period_ms});

  logic [1:0] code_one, code_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_ms  <= '0;
      rem100    <= '0;
      rem250    <= '0;
      dark100   <= 1'b0;
      dark250   <= 1'b0;
      wave_ms   <= '0;
      head      <= '0;
      load_flag <= 1'b0;
      load_pos  <= '0;
    end else if (cmd.start) begin
      blink_ms  <= blink_sum[31:0];
      rem100    <= rem100_next;
      rem250    <= rem250_next;
      dark100   <= dark100_next;
      dark250   <= dark250_next;
      load_flag <= wave_hit;
      load_pos  <= head;
      if (wave_hit) begin
        wave_ms <= '0;
        head    <= (head == HEAD_LAST) ? '0 : head + 1'b1;
      end else begin
        wave_ms <= wave_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      code_one <= status_one;
      code_two <= status_two;
    end
  end

  // Brightness store and fade
  logic [15:0]       level [WAVE_COUNT];
  logic [WIDX_W-1:0] widx;
  logic [15:0]       level_in;
  logic [31:0]       fade_prod;
  logic [15:0]       faded;
  logic [15:0]       lv;
  logic [23:0]       prod_r, prod_g, prod_b;

  assign widx      = cmd.item[WIDX_W-1:0];
  assign level_in  = (load_flag && (widx == load_pos)) ? sbwl_pkg::FULL_LEVEL : level[widx];
  assign fade_prod = {16'd0, level_in} * {16'd0, fade_factor};
  assign lv        = (faded < floor_level) ? 16'd0 : faded;
  assign prod_r    = {16'd0, wave_red} * {8'd0, lv};
  assign prod_g    = {16'd0, wave_green} * {8'd0, lv};
  assign prod_b    = {16'd0, wave_blue} * {8'd0, lv};

  always_ff @(posedge clk) begin
    if (cmd.wave_calc) faded <= fade_prod[31:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WAVE_COUNT; k++) level[k] <= '0;
    end else if (cmd.wave_done) begin
      level[widx] <= lv;
    end
  end

  // Output register
  sbwl_pkg::rgb_t status_rgb, wave_rgb;

  assign status_rgb = sbwl_pkg::status_colour(cmd.grp_two ? code_two : code_one,
                                              dark100, dark250);
  assign wave_rgb   = '{red: prod_r[23:16], green: prod_g[23:16], blue: prod_b[23:16]};
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      led_index <= cmd.led_index;
      last_led  <= cmd.last;
      out_rgb   <= cmd.wave_done ? wave_rgb : status_rgb;
    end
  end

endmodule

FILE: verif/sbwl_led_checker.sv
`timescale 1ns / 100ps

module sbwl_led_checker
  import sbwl_pkg::*;
#(
  parameter int GROUP_ONE_COUNT = GROUP_ONE_COUNT_DEF,
  parameter int GROUP_TWO_COUNT = GROUP_TWO_COUNT_DEF,
  parameter int WAVE_COUNT      = WAVE_COUNT_DEF,
  parameter int GROUP_ONE_START = GROUP_ONE_START_DEF,
  parameter int GROUP_TWO_START = GROUP_TWO_START_DEF,
  parameter int WAVE_START      = WAVE_START_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] status_one, [3:2] status_two, [7:4] zero
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [5:0] led_index, [13:6] red, [21:14] green,
                                      // [29:22] blue, [31:30] zero
  input  logic        m_axis_tlast,   // last_led
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned leds_pending,
  output int unsigned leds_checked,
  output int unsigned mismatch_count
);

  localparam logic [31:0] NET_BLINK_MS = 32'd100;
  localparam logic [31:0] CAN_BLINK_MS = 32'd250;
  localparam int unsigned REPORT_CAP   = 100;

  typedef struct {
    logic [IDX_W-1:0] led_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last_led;
  } led_color_t;

  led_color_t expected_leds[$];

  // Shadow of the register file
  logic [7:0]  frame_ms;
  logic [7:0]  wave_period_ms;
  logic [15:0] fade_factor;
  logic [15:0] floor_level;
  logic [7:0]  wave_red;
  logic [7:0]  wave_green;
  logic [7:0]  wave_blue;

  // Shadow of the frame state
  logic [31:0] blink_ms;
  logic [8:0]  wave_ms;
  int unsigned wave_ptr;
  logic [15:0] wave_level [WAVE_COUNT];

  function automatic led_color_t status_color(logic [1:0] code, logic [31:0] t,
                                              int unsigned pos);
    led_color_t c;
    logic net_lit;
    logic can_lit;
    net_lit     = ((t / NET_BLINK_MS) % 2) == 0;
    can_lit     = ((t / CAN_BLINK_MS) % 2) == 0;
    c.led_index = pos[IDX_W-1:0];
    c.red       = '0;
    c.green     = '0;
    c.blue      = '0;
    c.last_led  = 1'b0;
    case (code)
      STATUS_NET_DOWN: begin
        if (net_lit) c.red = LIT_LEVEL;
      end
      STATUS_CAN1_ERR: begin
        if (can_lit) begin
          c.red   = LIT_LEVEL;
          c.green = LIT_LEVEL;
        end
      end
      STATUS_CAN2_ERR: begin
        if (can_lit) begin
          c.red   = LIT_LEVEL;
          c.green = ORANGE_GREEN;
        end
      end
      default: begin
        c.red   = NORMAL_LEVEL;
        c.green = NORMAL_LEVEL;
        c.blue  = NORMAL_LEVEL;
      end
    endcase
    return c;
  endfunction

  // Truncating Q0.16 scale of one 8-bit color component
  function automatic logic [7:0] scale_component(logic [7:0] comp, logic [15:0] lvl);
    logic [23:0] prod;
    prod = 24'(comp) * 24'(lvl);
    return prod[23:16];
  endfunction

  task automatic predict_frame(input logic [1:0] code_one, input logic [1:0] code_two);
    led_color_t  frame_leds[$];
    led_color_t  c;
    logic [31:0] prod;
    logic [15:0] lvl;
    int unsigned n;
    blink_ms = blink_ms + frame_ms;
    for (int unsigned i = 0; i < GROUP_ONE_COUNT; i++)
      frame_leds.push_back(status_color(code_one, blink_ms, GROUP_ONE_START + i));
    for (int unsigned i = 0; i < GROUP_TWO_COUNT; i++)
      frame_leds.push_back(status_color(code_two, blink_ms, GROUP_TWO_START + i));

    wave_ms = wave_ms + frame_ms;
    if (wave_ms >= {1'b0, wave_period_ms}) begin
      wave_ms              = '0;
      wave_level[wave_ptr] = FULL_LEVEL;
      wave_ptr             = (wave_ptr + 1) % WAVE_COUNT;
    end

    for (int unsigned i = 0; i < WAVE_COUNT; i++) begin
      prod = 32'(wave_level[i]) * 32'(fade_factor);
      lvl  = prod[31:16];
      if (lvl < floor_level) lvl = '0;
      wave_level[i] = lvl;
      c.led_index = IDX_W'(WAVE_START + i);
      c.red       = scale_component(wave_red, lvl);
      c.green     = scale_component(wave_green, lvl);
      c.blue      = scale_component(wave_blue, lvl);
      c.last_led  = 1'b0;
      frame_leds.push_back(c);
    end

    // Cap the frame at the strip length; the final kept LED carries last
    n = (frame_leds.size() > MAX_LEDS) ? MAX_LEDS : frame_leds.size();
    for (int unsigned k = 0; k < n; k++) begin
      c          = frame_leds[k];
      c.last_led = (k == n - 1);
      expected_leds.push_back(c);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  task automatic check_led();
    led_color_t want;
    if (expected_leds.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $error("led_index %0d: LED color with no frame pending", m_axis_tdata[5:0]);
    end else begin
      want = expected_leds.pop_front();
      leds_checked++;
      check_field("led_index", 8'(want.led_index), 8'(m_axis_tdata[5:0]));
      check_field("red",       want.red,            m_axis_tdata[13:6]);
      check_field("green",     want.green,          m_axis_tdata[21:14]);
      check_field("blue",      want.blue,           m_axis_tdata[29:22]);
      check_field("last_led",  8'(want.last_led),   8'(m_axis_tlast));
    end
  endtask

  task automatic write_shadow(input logic [2:0] index, input logic [15:0] data);
    case (index)
      REG_FRAME_MS:    frame_ms       = data[7:0];
      REG_WAVE_PERIOD: wave_period_ms = data[7:0];
      REG_FADE:        fade_factor    = data;
      REG_FLOOR:       floor_level    = data;
      REG_WAVE_RED:    wave_red       = data[7:0];
      REG_WAVE_GREEN:  wave_green     = data[7:0];
      REG_WAVE_BLUE:   wave_blue      = data[7:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_ms       = FRAME_MS_RST;
      wave_period_ms = WAVE_PERIOD_RST;
      fade_factor    = FADE_RST;
      floor_level    = FLOOR_RST;
      wave_red       = WAVE_RED_RST;
      wave_green     = WAVE_GREEN_RST;
      wave_blue      = WAVE_BLUE_RST;
      blink_ms       = '0;
      wave_ms        = '0;
      wave_ptr       = 0;
      for (int i = 0; i < WAVE_COUNT; i++) wave_level[i] = '0;
      expected_leds.delete();
      leds_checked   = 0;
      mismatch_count = 0;
    end else begin
      // Outputs seen now belong to frames already predicted
      if (m_axis_tvalid && m_axis_tready) check_led();
      if (s_axis_tvalid && s_axis_tready) predict_frame(s_axis_tdata[1:0], s_axis_tdata[3:2]);
      if (cfg_valid && cfg_ready) write_shadow(cfg_index, cfg_data);
    end
    leds_pending <= expected_leds.size();
  end

endmodule

FILE: verif/status_blink_and_wave_led_frames_tb.sv
`timescale 1ns / 100ps

module status_blink_and_wave_led_frames_tb;
  import sbwl_pkg::*;

  // Index past the register list; the block must ignore writes to it
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // Random part: three idle mixes, a few register settings each
  localparam int unsigned SETTINGS_PER_MIX   = 4;
  localparam int unsigned FRAMES_PER_SETTING = 32;

  // Tail wait after the last LED: roughly one frame time of the block
  localparam int unsigned TAIL_CYCLES = 64;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = '0;    // [1:0] status_one, [3:2] status_two, [7:4] zero
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid     = 1'b0;
  logic [2:0]  cfg_index     = '0;
  logic [15:0] cfg_data      = '0;

  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;          // [5:0] led_index, [13:6] red, [21:14] green,
                                      // [29:22] blue, [31:30] zero
  logic        m_axis_tlast;          // last_led
  logic        cfg_ready;

  int unsigned leds_pending;
  int unsigned leds_checked;
  int unsigned mismatch_count;

  // Idle percentages for the sender and the receiver
  int unsigned tx_idle_pct = 30;
  int unsigned rx_idle_pct = 45;

  int unsigned frames_sent   = 0;
  int unsigned settings_used = 1;    // reset values count as the first setting

  logic [1:0] all_codes [4] = '{STATUS_NORMAL, STATUS_NET_DOWN,
                                STATUS_CAN1_ERR, STATUS_CAN2_ERR};

  always #5 clk = ~clk;

  status_blink_and_wave_led_frames i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Watches all three channels, predicts every LED color and compares
  sbwl_led_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .leds_pending   (leds_pending),
    .leds_checked   (leds_checked),
    .mismatch_count (mismatch_count)
  );

  // Receiver: stall at random per cycle; a zero percentage keeps tready high
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Safety net: far beyond the slowest correct run (64 LEDs per frame, each
  // held by the longest receiver stall, plus sender gaps and frame time)
  initial begin
    #(64'd20_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // Present one frame request and hold it until it is taken. Valid is left
  // high on return so that back-to-back requests never toggle it within a step.
  task automatic send_frame(input logic [1:0] code_one, input logic [1:0] code_two);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, code_two, code_one};
    do @(posedge clk); while (!s_axis_tready);
    frames_sent++;
  endtask

  // Drop the request and hold off until every predicted LED has come out
  task automatic drain_leds();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (leds_pending != 0);
  endtask

  // Hold one register write until it is taken; the caller lowers valid
  task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write the whole register file. Eight-bit registers get random junk in the
  // upper byte, which must be dropped, and the unused index gets a write too.
  task automatic program_regs(input logic [7:0] frame_ms, input logic [7:0] period_ms,
                              input logic [15:0] fade, input logic [15:0] floor_lvl,
                              input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
    write_reg(REG_FRAME_MS,    {8'($urandom), frame_ms});
    write_reg(REG_WAVE_PERIOD, {8'($urandom), period_ms});
    write_reg(REG_FADE,        fade);
    write_reg(REG_FLOOR,       floor_lvl);
    write_reg(REG_WAVE_RED,    {8'($urandom), red});
    write_reg(REG_WAVE_GREEN,  {8'($urandom), green});
    write_reg(REG_WAVE_BLUE,   {8'($urandom), blue});
    write_reg(REG_UNUSED,      16'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // One time in eight the low end, one in eight the high end, else a range
  function automatic int unsigned pick_value(int unsigned low_end, int unsigned high_end,
                                             int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 7))
      0:       return low_end;
      1:       return high_end;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Mostly long fade tails and low floors so the wave stays visible
  task automatic random_setting();
    program_regs(8'(pick_value(1, 255, 1, 120)),
                 8'(pick_value(0, 255, 1, 255)),
                 16'(pick_value(0, 65535, 30000, 65535)),
                 16'(pick_value(0, 65535, 0, 4000)),
                 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
  endtask

  task automatic random_frames(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      send_frame(all_codes[$urandom_range(0, 3)], all_codes[$urandom_range(0, 3)]);
      // Now and then let the block run dry before the next request
      if ($urandom_range(0, 39) == 0) drain_leds();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset values first: every pair of status codes. At 20 ms per frame the
    // blink timer crosses both the 100 ms and the 250 ms phase edges.
    foreach (all_codes[a]) begin
      foreach (all_codes[b]) begin
        send_frame(all_codes[a], all_codes[b]);
      end
    end
    drain_leds();

    // Longest frame, shortest nonzero period, full fade with no floor, white wave
    program_regs(8'd255, 8'd1, 16'hFFFF, 16'h0000, 8'd255, 8'd255, 8'd255);
    send_frame(STATUS_NET_DOWN, STATUS_CAN2_ERR);
    send_frame(STATUS_CAN1_ERR, STATUS_NORMAL);
    send_frame(STATUS_CAN2_ERR, STATUS_NET_DOWN);
    send_frame(STATUS_NORMAL, STATUS_CAN1_ERR);
    drain_leds();

    // Shortest nonzero frame, longest period, zero fade, top floor, black wave
    program_regs(8'd1, 8'd255, 16'h0000, 16'hFFFF, 8'd0, 8'd0, 8'd0);
    send_frame(STATUS_CAN2_ERR, STATUS_CAN2_ERR);
    send_frame(STATUS_NET_DOWN, STATUS_NET_DOWN);
    drain_leds();

    // Zero wave period: a new head lights on every frame
    program_regs(8'd128, 8'd0, 16'h8000, 16'h0001, 8'd255, 8'd0, 8'd128);
    send_frame(STATUS_CAN1_ERR, STATUS_CAN2_ERR);
    send_frame(STATUS_NORMAL, STATUS_NET_DOWN);
    send_frame(STATUS_NET_DOWN, STATUS_CAN1_ERR);
    drain_leds();

    // Random part: sender 30 / receiver 45, then swapped, then no idling
    for (int mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin
          tx_idle_pct = 30;
          rx_idle_pct = 45;
        end
        1: begin
          tx_idle_pct = 45;
          rx_idle_pct = 30;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int unsigned s = 0; s < SETTINGS_PER_MIX; s++) begin
        random_setting();
        random_frames(FRAMES_PER_SETTING);
        drain_leds();
      end
    end

    // Any stray LED after this point shows up as unexpected in the checker
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d frame ticks under %0d register settings; %0d LED colors compared.",
             frames_sent, settings_used, leds_checked);
    $display("Covered all status pairs, blink edges, zero period, fade and floor extremes,");
    $display("ignored register index, and three sender/receiver idle mixes.");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sbwl_pkg.sv
rtl/core/sbwl_ctrl.sv
rtl/core/sbwl_dp.sv
rtl/core/status_blink_and_wave_led_frames.sv
verif/sbwl_led_checker.sv
verif/status_blink_and_wave_led_frames_tb.sv
